### rtl/npe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npe_pkg
// Shared constants and types for the next permutation engine: store depth,
// field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package npe_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 4;
    localparam int OP_W         = 2;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_STEP  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT,
        ST_SUCC_RD,
        ST_SUCC,
        ST_SWAP,
        ST_REV_RD,
        ST_REV_WA,
        ST_REV_WB
    } state_t;

endpackage : npe_pkg
`default_nettype wire

### rtl/next_permutation_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// next_permutation_engine_core
// Holds up to MAX_ELEMENTS signed values and steps them through their
// lexicographic arrangements. Input channel s_* takes clear, load and step
// operations; a load inserts its value at its ascending sorted place and is
// dropped when the store is full. A step produces one m_* transfer per
// element of the current arrangement (position, last_of_run flag, and
// final_arrangement when no next arrangement exists), then rewrites the
// store to the next arrangement. s_ready is high only between operations.
// Order of work: a load moves each larger element up one place; a step
// runs the pivot scan, the run (one element per cycle while m_ready is
// high), the successor scan, the swap and the suffix reversal pair by
// pair, on a two-read, one-write store.
// A stalled m_ready holds the run at the output register; the last result
// may wait there while the next operation is already taken.
// Synchronous active-low reset empties the store and drops any result.
// ----------------------------------------------------------------------------
module next_permutation_engine_core
    import npe_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [OP_W-1:0]          s_op,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_element,
    output logic [POS_W-1:0]              m_position,
    output logic                          m_last_of_run,
    output logic                          m_final_arrangement
);

    elem_t  store_mem [MAX_ELEMENTS];
    elem_t  rd_a_reg, rd_b_reg;
    logic   rd_en;
    idx_t   rd_addr_a, rd_addr_b;
    logic   wr_en;
    idx_t   wr_addr;
    elem_t  wr_data;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    idx_t   k_reg, k_next;
    idx_t   hi_reg, hi_next;
    idx_t   piv_idx_reg, piv_idx_next;
    elem_t  piv_val_reg, piv_val_next;
    elem_t  val_reg, val_next;
    logic   found_reg, found_next;

    logic              m_valid_reg, m_valid_next;
    elem_t             m_element_reg, m_element_next;
    logic [POS_W-1:0]  m_position_reg, m_position_next;
    logic              m_last_reg, m_last_next;
    logic              m_final_reg, m_final_next;

    logic   out_free;
    logic   is_last;
    idx_t   lo_inc, hi_dec;

    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;
    assign lo_inc   = k_reg + IDX_W'(1);
    assign hi_dec   = hi_reg - IDX_W'(1);

    // store with one write and two registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= store_mem[rd_addr_a];
            rd_b_reg <= store_mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        hi_reg         <= hi_next;
        piv_idx_reg    <= piv_idx_next;
        piv_val_reg    <= piv_val_next;
        val_reg        <= val_next;
        found_reg      <= found_next;
        m_element_reg  <= m_element_next;
        m_position_reg <= m_position_next;
        m_last_reg     <= m_last_next;
        m_final_reg    <= m_final_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        hi_next         = hi_reg;
        piv_idx_next    = piv_idx_reg;
        piv_val_next    = piv_val_reg;
        val_next        = val_reg;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_element_next  = m_element_reg;
        m_position_next = m_position_reg;
        m_last_next     = m_last_reg;
        m_final_next    = m_final_reg;
        rd_en           = 1'b0;
        rd_addr_a       = k_reg;
        rd_addr_b       = hi_reg;
        wr_en           = 1'b0;
        wr_addr         = k_reg;
        wr_data         = val_reg;
        s_ready         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_op)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_LOAD: begin
                            if (count_reg < CNT_W'(MAX_ELEMENTS)) begin
                                val_next   = s_value;
                                k_next     = IDX_W'(count_reg);
                                rd_en      = 1'b1;
                                rd_addr_a  = IDX_W'(count_reg - CNT_W'(1));
                                state_next = ST_LOAD;
                            end
                        end
                        OP_STEP: begin
                            if (count_reg == CNT_W'(1)) begin
                                found_next = 1'b0;
                                k_next     = '0;
                                state_next = ST_EMIT_RD;
                            end else if (count_reg != '0) begin
                                k_next     = IDX_W'(count_reg - CNT_W'(1));
                                rd_en      = 1'b1;
                                rd_addr_a  = IDX_W'(count_reg - CNT_W'(2));
                                rd_addr_b  = IDX_W'(count_reg - CNT_W'(1));
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // shift larger entries up until the insert point is found
            ST_LOAD: begin
                wr_en = 1'b1;
                if (k_reg != '0 && (val_reg < rd_a_reg)) begin
                    wr_data   = rd_a_reg;
                    k_next    = k_reg - IDX_W'(1);
                    rd_en     = 1'b1;
                    rd_addr_a = k_reg - IDX_W'(2);
                end else begin
                    wr_data    = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            // pivot search from the right
            ST_SCAN: begin
                if (rd_a_reg < rd_b_reg) begin
                    found_next   = 1'b1;
                    piv_idx_next = k_reg - IDX_W'(1);
                    piv_val_next = rd_a_reg;
                    k_next       = '0;
                    state_next   = ST_EMIT_RD;
                end else if (k_reg == IDX_W'(1)) begin
                    found_next = 1'b0;
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    k_next    = k_reg - IDX_W'(1);
                    rd_en     = 1'b1;
                    rd_addr_a = k_reg - IDX_W'(2);
                    rd_addr_b = k_reg - IDX_W'(1);
                end
            end
            ST_EMIT_RD: begin
                rd_en      = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_element_next  = rd_a_reg;
                    m_position_next = POS_W'(k_reg);
                    m_last_next     = is_last;
                    m_final_next    = !found_reg;
                    if (is_last) begin
                        k_next     = IDX_W'(count_reg - CNT_W'(1));
                        state_next = found_reg ? ST_SUCC_RD : ST_IDLE;
                    end else begin
                        k_next    = lo_inc;
                        rd_en     = 1'b1;
                        rd_addr_a = lo_inc;
                    end
                end
            end
            ST_SUCC_RD: begin
                rd_en      = 1'b1;
                state_next = ST_SUCC;
            end
            // rightmost element greater than the pivot
            ST_SUCC: begin
                if (piv_val_reg < rd_a_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = piv_idx_reg;
                    wr_data    = rd_a_reg;
                    state_next = ST_SWAP;
                end else begin
                    k_next    = k_reg - IDX_W'(1);
                    rd_en     = 1'b1;
                    rd_addr_a = k_reg - IDX_W'(1);
                end
            end
            ST_SWAP: begin
                wr_en   = 1'b1;
                wr_data = piv_val_reg;
                k_next  = piv_idx_reg + IDX_W'(1);
                hi_next = IDX_W'(count_reg - CNT_W'(1));
                if (CNT_W'(piv_idx_reg) + CNT_W'(2) < count_reg) begin
                    state_next = ST_REV_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            // suffix reversal, one pair per pass through ST_REV_RD, ST_REV_WA and ST_REV_WB
            ST_REV_RD: begin
                rd_en      = 1'b1;
                state_next = ST_REV_WA;
            end
            ST_REV_WA: begin
                wr_en      = 1'b1;
                wr_data    = rd_b_reg;
                state_next = ST_REV_WB;
            end
            ST_REV_WB: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = rd_a_reg;
                k_next  = lo_inc;
                hi_next = hi_dec;
                if (lo_inc < hi_dec) begin
                    state_next = ST_REV_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid             = m_valid_reg;
    assign m_element           = m_element_reg;
    assign m_position          = m_position_reg;
    assign m_last_of_run       = m_last_reg;
    assign m_final_arrangement = m_final_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count above capacity");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (k_reg != '0 && CNT_W'(k_reg) < count_reg))
        else $error("pivot scan index out of range");

    a_succ_right_of_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUCC) |-> (k_reg > piv_idx_reg))
        else $error("successor search passed the pivot");

    a_rev_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REV_RD) |-> (k_reg < hi_reg))
        else $error("reversal indices crossed");

    a_run_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && state_next != ST_EMIT) |=> (m_valid && m_last_of_run))
        else $error("run left without a last element");

endmodule : next_permutation_engine_core
`default_nettype wire
